// File: sv/usa_pkg.sv
package usa_pkg;

  localparam int unsigned ID_W        = 16;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned SUB_W       = 50;
  localparam int unsigned LVL_W       = 4;
  localparam int unsigned ENT_W       = ID_W + IDX_W;
  localparam int unsigned TOP_LEVEL   = 8;
  localparam int unsigned MAX_UES_DEF = 64;
  localparam int unsigned STEP_W      = 4;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] ST_IDLE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_CHK    = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_S_RD   = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_S_CMP  = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_DECIDE = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_I_INIT = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_I_RD   = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_I_WR   = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_PUT    = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_R_RD   = STEP_W'(9);
  localparam logic [STEP_W-1:0] ST_R_WR   = STEP_W'(10);
  localparam logic [STEP_W-1:0] ST_FULL   = STEP_W'(11);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SCAN,
    OP_DECIDE,
    OP_LOAD,
    OP_SHIFT,
    OP_PUT,
    OP_RENUM,
    OP_FULL
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NSTART,
    C_FULL,
    C_PTR_END,
    C_ID_LE,
    C_RENUM,
    C_AT_POS
  } cond_e;

  typedef enum logic {
    RA_PTR,
    RA_PTR_M1
  } rsel_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    rsel_e             rsel;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic full;
    logic ptr_end;
    logic id_le;
    logic renum;
    logic at_pos;
  } flags_t;

  // control store: jump to target when cond holds, else next step
  function automatic ctrl_t ucode(logic [STEP_W-1:0] s);
    ctrl_t c;
    case (s)
      ST_IDLE:   c = '{OP_CAPTURE, C_NSTART,  RA_PTR,    ST_IDLE};
      ST_CHK:    c = '{OP_NONE,    C_FULL,    RA_PTR,    ST_FULL};
      ST_S_RD:   c = '{OP_NONE,    C_PTR_END, RA_PTR,    ST_DECIDE};
      ST_S_CMP:  c = '{OP_SCAN,    C_ID_LE,   RA_PTR,    ST_S_RD};
      ST_DECIDE: c = '{OP_DECIDE,  C_RENUM,   RA_PTR,    ST_R_RD};
      ST_I_INIT: c = '{OP_LOAD,    C_NEVER,   RA_PTR,    ST_IDLE};
      ST_I_RD:   c = '{OP_NONE,    C_AT_POS,  RA_PTR_M1, ST_PUT};
      ST_I_WR:   c = '{OP_SHIFT,   C_ALWAYS,  RA_PTR,    ST_I_RD};
      ST_PUT:    c = '{OP_PUT,     C_ALWAYS,  RA_PTR,    ST_IDLE};
      ST_R_RD:   c = '{OP_NONE,    C_PTR_END, RA_PTR,    ST_I_INIT};
      ST_R_WR:   c = '{OP_RENUM,   C_ALWAYS,  RA_PTR,    ST_R_RD};
      ST_FULL:   c = '{OP_FULL,    C_ALWAYS,  RA_PTR,    ST_IDLE};
      default:   c = '{OP_NONE,    C_ALWAYS,  RA_PTR,    ST_IDLE};
    endcase
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] band_size(logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] v;
    case (lvl)
      LVL_W'(1): v = IDX_W'(2);
      LVL_W'(2): v = IDX_W'(5);
      LVL_W'(3): v = IDX_W'(10);
      LVL_W'(4): v = IDX_W'(20);
      LVL_W'(5): v = IDX_W'(40);
      LVL_W'(6): v = IDX_W'(80);
      LVL_W'(7): v = IDX_W'(160);
      LVL_W'(8): v = IDX_W'(320);
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] band_low(logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] v;
    case (lvl)
      LVL_W'(2): v = IDX_W'(2);
      LVL_W'(3): v = IDX_W'(7);
      LVL_W'(4): v = IDX_W'(17);
      LVL_W'(5): v = IDX_W'(37);
      LVL_W'(6): v = IDX_W'(77);
      LVL_W'(7): v = IDX_W'(157);
      LVL_W'(8): v = IDX_W'(317);
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/usa_ram.sv
module usa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/usa_seq.sv
module usa_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  usa_pkg::flags_t flags_i,
  output usa_pkg::ctrl_t  ctrl_o,
  output logic            busy_o
);
  import usa_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic              take;

  assign ctrl_o = ucode(step_q);
  assign busy_o = (step_q != ST_IDLE);

  always_comb begin
    unique case (ctrl_o.cond)
      C_NEVER:   take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_NSTART:  take = !flags_i.start;
      C_FULL:    take = flags_i.full;
      C_PTR_END: take = flags_i.ptr_end;
      C_ID_LE:   take = flags_i.id_le;
      C_RENUM:   take = flags_i.renum;
      C_AT_POS:  take = flags_i.at_pos;
      default:   take = 1'b0;
    endcase
    step_d = take ? ctrl_o.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: sv/ue_id_and_sounding_slot_allocator_core.sv
// Channel   Direction  Handshake                 Payload
// request   in         start / busy              subscriber_id_i
// result    out        res_valid_o (one cycle)   ue_id_o, sounding_index_o, subscriber_echo_o,
//                                                is_reconfig_o, status_o, last_o
// config    in         cfg_valid_i / cfg_ready_o rnti_start_i
//
// Busy covers the full check, the id search (which may run off the table end, or wrap to id 1
// and rescan from the table head), the sorted insert that moves later entries up and, on a band
// change, the renumber of all stored UEs; the setup result is valid in the first cycle with busy low.
// A full table also gives its result once busy is low. Renumber results leave one per stored UE, never back to back.
// Reset clears count, level, last id and last index; the table RAM is not cleared.
// The receiver cannot stall: each result is presented for exactly one cycle.
module ue_id_and_sounding_slot_allocator_core #(
  parameter int unsigned MAX_UES = usa_pkg::MAX_UES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [usa_pkg::SUB_W-1:0] subscriber_id_i,
  output logic                      res_valid_o,
  output logic [usa_pkg::ID_W-1:0]  ue_id_o,
  output logic [usa_pkg::IDX_W-1:0] sounding_index_o,
  output logic [usa_pkg::SUB_W-1:0] subscriber_echo_o,
  output logic                      is_reconfig_o,
  output logic                      status_o,
  output logic                      last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [usa_pkg::ID_W-1:0]  rnti_start_i
);
  import usa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_UES);
  localparam int unsigned CW = $clog2(MAX_UES + 1);

  ctrl_t  ctrl;
  flags_t flags;

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [ID_W-1:0]  last_id_q, last_id_d;
  logic [IDX_W-1:0] last_idx_q, last_idx_d;

  logic [SUB_W-1:0] sub_q, sub_d;
  logic [ID_W-1:0]  cand_q, cand_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [IDX_W-1:0] nidx_q, nidx_d;

  logic             res_valid_q, res_valid_d;
  logic [ID_W-1:0]  res_id_q, res_id_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic [SUB_W-1:0] res_sub_q, res_sub_d;
  logic             res_rcf_q, res_rcf_d;
  logic             res_st_q, res_st_d;
  logic             res_last_q, res_last_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic [ID_W-1:0]  rd_id;
  logic [CW-1:0]    ptr_m1;
  logic [LVL_W-1:0] lvl_inc;
  logic             renum_w;

  usa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // table entry: {ue id, sounding index}, kept sorted by id
  usa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_UES)
  ) u_tbl (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_id     = ram_rdata[ENT_W-1 -: ID_W];
  assign ptr_m1    = ptr_q - CW'(1);
  assign lvl_inc   = lvl_q + LVL_W'(1);
  assign ram_raddr = (ctrl.rsel == RA_PTR) ? ptr_q[AW-1:0] : ptr_m1[AW-1:0];

  // band full: move up one level and renumber everything
  assign renum_w = (lvl_q != '0) && (lvl_q < LVL_W'(TOP_LEVEL)) &&
                   (IDX_W'(cnt_q) == band_size(lvl_q));

  assign cfg_ready_o = !busy;

  always_comb begin
    flags.start   = start;
    flags.full    = (cnt_q == CW'(MAX_UES));
    flags.ptr_end = (ptr_q == cnt_q);
    flags.id_le   = (rd_id <= cand_q);
    flags.renum   = renum_w;
    flags.at_pos  = (ptr_q == pos_q);
  end

  always_comb begin
    cnt_d       = cnt_q;
    lvl_d       = lvl_q;
    last_id_d   = last_id_q;
    last_idx_d  = last_idx_q;
    sub_d       = sub_q;
    cand_d      = cand_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    nidx_d      = nidx_q;
    res_valid_d = 1'b0;
    res_id_d    = res_id_q;
    res_idx_d   = res_idx_q;
    res_sub_d   = res_sub_q;
    res_rcf_d   = res_rcf_q;
    res_st_d    = res_st_q;
    res_last_d  = res_last_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q[AW-1:0];
    ram_wdata   = ram_rdata;

    if (cfg_valid_i && cfg_ready_o) begin
      last_id_d = rnti_start_i;
    end

    unique case (ctrl.op)
      OP_NONE: begin
      end
      OP_CAPTURE: begin
        sub_d  = subscriber_id_i;
        cand_d = (last_id_q == '0) ? ID_W'(1) : last_id_q;
        ptr_d  = '0;
      end
      OP_SCAN: begin
        if (rd_id == cand_q) begin
          if (cand_q == '1) begin
            // id space wraps past zero: restart at id 1 from the table head
            cand_d = ID_W'(1);
            ptr_d  = '0;
          end else begin
            cand_d = cand_q + ID_W'(1);
            ptr_d  = ptr_q + CW'(1);
          end
        end else if (rd_id < cand_q) begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      OP_DECIDE: begin
        pos_d = ptr_q;
        ptr_d = '0;
        if (lvl_q == '0) begin
          nidx_d = '0;
          lvl_d  = LVL_W'(1);
        end else if (renum_w) begin
          lvl_d  = lvl_inc;
          nidx_d = band_low(lvl_inc);
        end else begin
          nidx_d = last_idx_q + IDX_W'(1);
        end
      end
      OP_LOAD: begin
        ptr_d = cnt_q;
      end
      OP_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[AW-1:0];
        ram_wdata = ram_rdata;
        ptr_d     = ptr_m1;
      end
      OP_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_q[AW-1:0];
        ram_wdata   = {cand_q, nidx_q};
        cnt_d       = cnt_q + CW'(1);
        last_id_d   = cand_q;
        last_idx_d  = nidx_q;
        res_valid_d = 1'b1;
        res_id_d    = cand_q;
        res_idx_d   = nidx_q;
        res_sub_d   = sub_q;
        res_rcf_d   = 1'b0;
        res_st_d    = 1'b0;
        res_last_d  = 1'b1;
      end
      OP_RENUM: begin
        ram_we      = 1'b1;
        ram_waddr   = ptr_q[AW-1:0];
        ram_wdata   = {rd_id, nidx_q};
        ptr_d       = ptr_q + CW'(1);
        nidx_d      = nidx_q + IDX_W'(1);
        res_valid_d = 1'b1;
        res_id_d    = rd_id;
        res_idx_d   = nidx_q;
        res_sub_d   = '0;
        res_rcf_d   = 1'b1;
        res_st_d    = 1'b0;
        res_last_d  = 1'b0;
      end
      OP_FULL: begin
        res_valid_d = 1'b1;
        res_id_d    = '0;
        res_idx_d   = '0;
        res_sub_d   = sub_q;
        res_rcf_d   = 1'b0;
        res_st_d    = 1'b1;
        res_last_d  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      lvl_q       <= '0;
      last_id_q   <= '0;
      last_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      lvl_q       <= lvl_d;
      last_id_q   <= last_id_d;
      last_idx_q  <= last_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sub_q      <= sub_d;
    cand_q     <= cand_d;
    ptr_q      <= ptr_d;
    pos_q      <= pos_d;
    nidx_q     <= nidx_d;
    res_id_q   <= res_id_d;
    res_idx_q  <= res_idx_d;
    res_sub_q  <= res_sub_d;
    res_rcf_q  <= res_rcf_d;
    res_st_q   <= res_st_d;
    res_last_q <= res_last_d;
  end

  assign res_valid_o       = res_valid_q;
  assign ue_id_o           = res_id_q;
  assign sounding_index_o  = res_idx_q;
  assign subscriber_echo_o = res_sub_q;
  assign is_reconfig_o     = res_rcf_q;
  assign status_o          = res_st_q;
  assign last_o            = res_last_q;

  a_full_only_at_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o |-> cnt_q == CW'(MAX_UES))
    else $error("full status while table has room");

  a_setup_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !is_reconfig_o && !status_o |-> (cnt_q - $past(cnt_q)) == CW'(1))
    else $error("setup result without count increment");

  a_reconfig_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && is_reconfig_o |-> (lvl_q >= LVL_W'(2)) && !last_o && !status_o)
    else $error("renumber result out of place");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request transfer did not start the sequencer");

endmodule
